/* hw/rtl/qpd_pkg.sv */
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types and constants of the quoted-printable decoder core.
// ----------------------------------------------------------------------------
package qpd_pkg;

  // Width of the per-message decoded byte counter.
  localparam int unsigned COUNT_BITS = 16;
  // Width of the byte count carried on the result beat.
  localparam int unsigned COUNT_OUT_BITS = 16;

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
  localparam logic [7:0] PLAIN_LO     = 8'h21;
  localparam logic [7:0] PLAIN_HI     = 8'h7e;
  localparam logic [7:0] DIGIT_LO     = 8'h30;
  localparam logic [7:0] DIGIT_HI     = 8'h39;
  localparam logic [7:0] UPPER_LO     = 8'h41;
  localparam logic [7:0] UPPER_HI     = 8'h5a;
  localparam logic [7:0] LOWER_LO     = 8'h61;
  localparam logic [7:0] LOWER_HI     = 8'h7a;
  localparam logic [7:0] UPPER_OFS    = 8'h37;
  localparam logic [7:0] LOWER_OFS    = 8'h57;
  localparam logic [7:0] HIGH_MASK    = 8'hf0;
  localparam logic [3:0] NIBBLE_MASK  = 4'hf;

  // Escape sequence position; code 3 never arises and decodes as ESC_LOW.
  typedef enum logic [1:0] {
    ESC_PLAIN = 2'd0,
    ESC_HIGH  = 2'd1,
    ESC_LOW   = 2'd2
  } esc_phase_e;

  // Classification of one encoded character.
  typedef struct packed {
    logic       plain_ok;  // legal outside an escape
    logic       is_equals; // escape introducer
    logic       alnum;     // legal inside an escape
    logic [3:0] nibble;    // lenient nibble value
  } char_class_t;

  // One result beat.
  typedef struct packed {
    logic [COUNT_OUT_BITS-1:0] byte_count;
    logic                      bad_input;
    logic                      message_done;
    logic                      byte_valid;
    logic [7:0]                out_byte;
  } qpd_result_t;

  // Clamp the internal counter to the result field width.
  function automatic logic [COUNT_OUT_BITS-1:0] cap_count(input logic [COUNT_BITS-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    if (wide > 32'(16'hffff)) begin
      cap_count = {COUNT_OUT_BITS{1'b1}};
    end else begin
      cap_count = wide[COUNT_OUT_BITS-1:0];
    end
  endfunction

endpackage

/* hw/rtl/quoted_printable_decoder_core.sv */
// ----------------------------------------------------------------------------
// quoted_printable_decoder_core
// Streaming quoted-printable decoder, one encoded character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one encoded character per beat on s_axis_tdata_i, with
//   s_axis_tlast_i high on the final character of a message.
//   Master channel: at most one result beat per input beat. A beat carries
//   a decoded byte (tuser bit 0), the end of a message (tlast), an abort on
//   an illegal character (tuser bit 1) and, at message end, the saturating
//   byte count. Escape openers and legal high nibbles that do not end the
//   message, and the rest of an aborted message, produce no beat.
//   Path: a character accepted into the input register passes the decode
//   stage and gives its result beat from the result register.
//   Throughput: one character per cycle while m_axis_tready_i stays high,
//   through the single decode stage between the input and result registers.
//   Stall: when the receiver holds m_axis_tready_i low with a result
//   pending, the decode stage holds its character and the slave channel
//   takes at most one more beat into the input register, then stalls.
//   Reset: rst_ni clears both pipeline valid flags, the escape state, the
//   discard flag and the byte counter; the first character after reset
//   starts a new message.
// ----------------------------------------------------------------------------
module quoted_printable_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] char_in
  input  logic        s_axis_tlast_i,  // last_char
  // Master channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [7:0] out_byte, [23:8] byte_count
  output logic [1:0]  m_axis_tuser_o,  // [0] byte_valid, [1] bad_input
  output logic        m_axis_tlast_o   // message_done
);

  // Input register
  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_char_q;
  logic                 in_last_q;

  // Result register
  logic                 out_valid_q, out_valid_d;
  qpd_pkg::qpd_result_t out_res_q;

  logic                 advance;
  logic                 res_valid;
  qpd_pkg::qpd_result_t res;
  qpd_pkg::char_class_t char_class;

  // Advance the decode stage whenever it holds a character and the result register can take a beat.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign in_valid_d  = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !advance);
  assign out_valid_d = (advance && res_valid) || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on accept or on a new result, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  qpd_char_class u_char_class (
    .char_i  (in_char_q),
    .class_o (char_class)
  );

  qpd_decode_fsm u_decode_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .char_i      (in_char_q),
    .last_i      (in_last_q),
    .class_i     (char_class),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.byte_count, out_res_q.out_byte};
  assign m_axis_tuser_o  = {out_res_q.bad_input, out_res_q.byte_valid};
  assign m_axis_tlast_o  = out_res_q.message_done;

endmodule

/* hw/rtl/qpd_char_class.sv */
// ----------------------------------------------------------------------------
// qpd_char_class
// Classifies one encoded character and maps it to a nibble value.
// ----------------------------------------------------------------------------
module qpd_char_class (
  input  logic [7:0]           char_i,
  output qpd_pkg::char_class_t class_o
);

  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] upper_val;
  logic [7:0] lower_val;

  assign is_digit = (char_i >= qpd_pkg::DIGIT_LO) && (char_i <= qpd_pkg::DIGIT_HI);
  assign is_upper = (char_i >= qpd_pkg::UPPER_LO) && (char_i <= qpd_pkg::UPPER_HI);
  assign is_lower = (char_i >= qpd_pkg::LOWER_LO) && (char_i <= qpd_pkg::LOWER_HI);

  // Letters past 'F' wrap around the nibble range.
  assign upper_val = char_i - qpd_pkg::UPPER_OFS;
  assign lower_val = char_i - qpd_pkg::LOWER_OFS;

  always_comb begin
    class_o.plain_ok  = ((char_i >= qpd_pkg::PLAIN_LO) && (char_i <= qpd_pkg::PLAIN_HI)) ||
                        (char_i == qpd_pkg::CHAR_SPACE) || (char_i == qpd_pkg::CHAR_TAB);
    class_o.is_equals = (char_i == qpd_pkg::CHAR_EQUALS);
    class_o.alnum     = is_digit || is_upper || is_lower;
    if (is_digit) begin
      class_o.nibble = char_i[3:0];
    end else if (is_upper) begin
      class_o.nibble = upper_val[3:0] & qpd_pkg::NIBBLE_MASK;
    end else begin
      class_o.nibble = lower_val[3:0] & qpd_pkg::NIBBLE_MASK;
    end
  end

endmodule

/* hw/rtl/qpd_decode_fsm.sv */
// ----------------------------------------------------------------------------
// qpd_decode_fsm
// Escape state machine, message counter and result forming for one beat.
// ----------------------------------------------------------------------------
module qpd_decode_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [7:0]                  char_i,
  input  logic                        last_i,
  input  qpd_pkg::char_class_t        class_i,
  output logic                        res_valid_o,
  output qpd_pkg::qpd_result_t        res_o
);

  qpd_pkg::esc_phase_e               phase_q, phase_d;
  logic [3:0]                        high_q, high_d;
  logic                              discard_q, discard_d;
  logic [qpd_pkg::COUNT_BITS-1:0]    count_q, count_d;
  logic [qpd_pkg::COUNT_BITS-1:0]    count_inc;
  logic [7:0]                        esc_byte;

  assign count_inc = (count_q == {qpd_pkg::COUNT_BITS{1'b1}}) ? count_q
                                                               : count_q + 1'b1;
  assign esc_byte  = ({high_q, 4'h0} & qpd_pkg::HIGH_MASK) | {4'h0, class_i.nibble};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= qpd_pkg::ESC_PLAIN;
      high_q    <= '0;
      discard_q <= 1'b0;
      count_q   <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      high_q    <= high_d;
      discard_q <= discard_d;
      count_q   <= count_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    high_d      = high_q;
    discard_d   = discard_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (discard_q) begin
      // Drop the rest of an aborted message.
      if (last_i) begin
        discard_d = 1'b0;
      end
    end else begin
      unique case (phase_q)
        qpd_pkg::ESC_PLAIN: begin
          if (!class_i.plain_ok) begin
            res_valid_o        = 1'b1;
            res_o.message_done = 1'b1;
            res_o.bad_input    = 1'b1;
            res_o.byte_count   = qpd_pkg::cap_count(count_q);
            discard_d          = !last_i;
          end else if (class_i.is_equals) begin
            if (last_i) begin
              // Soft line break at message end.
              res_valid_o        = 1'b1;
              res_o.message_done = 1'b1;
              res_o.byte_count   = qpd_pkg::cap_count(count_q);
            end else begin
              phase_d = qpd_pkg::ESC_HIGH;
              high_d  = '0;
            end
          end else begin
            res_valid_o        = 1'b1;
            res_o.out_byte     = char_i;
            res_o.byte_valid   = 1'b1;
            res_o.message_done = last_i;
            res_o.byte_count   = last_i ? qpd_pkg::cap_count(count_inc) : '0;
            count_d            = count_inc;
          end
        end
        qpd_pkg::ESC_HIGH: begin
          if (!class_i.alnum) begin
            res_valid_o        = 1'b1;
            res_o.message_done = 1'b1;
            res_o.bad_input    = 1'b1;
            res_o.byte_count   = qpd_pkg::cap_count(count_q);
            discard_d          = !last_i;
          end else begin
            high_d  = class_i.nibble;
            phase_d = qpd_pkg::ESC_LOW;
            if (last_i) begin
              // Unfinished escape: end the message without a byte.
              res_valid_o        = 1'b1;
              res_o.message_done = 1'b1;
              res_o.byte_count   = qpd_pkg::cap_count(count_q);
            end
          end
        end
        default: begin
          if (!class_i.alnum) begin
            res_valid_o        = 1'b1;
            res_o.message_done = 1'b1;
            res_o.bad_input    = 1'b1;
            res_o.byte_count   = qpd_pkg::cap_count(count_q);
            discard_d          = !last_i;
          end else begin
            res_valid_o        = 1'b1;
            res_o.out_byte     = esc_byte;
            res_o.byte_valid   = 1'b1;
            res_o.message_done = last_i;
            res_o.byte_count   = last_i ? qpd_pkg::cap_count(count_inc) : '0;
            count_d            = count_inc;
            phase_d            = qpd_pkg::ESC_PLAIN;
            high_d             = '0;
          end
        end
      endcase

      // Message end returns every state entry to reset.
      if (last_i) begin
        phase_d   = qpd_pkg::ESC_PLAIN;
        high_d    = '0;
        discard_d = 1'b0;
        count_d   = '0;
      end
    end

    if (discard_q && last_i) begin
      phase_d = qpd_pkg::ESC_PLAIN;
      high_d  = '0;
      count_d = '0;
    end
  end

endmodule
